/* hw/rtl/epd_pkg.sv */
// ----------------------------------------------------------------------------
// epd_pkg
// Types, codes and helpers shared by the encapsulation packet deframer.
// ----------------------------------------------------------------------------
package epd_pkg;

  localparam int DEF_OUT_DEPTH = 4;

  localparam int NIBBLE_W  = 4;
  localparam int DEFINED_W = 16;
  localparam int LENGTH_W  = 32;
  localparam int HDR_W     = 64;

  // Result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_HDR_TRUNC  = 2'd1;
  localparam logic [1:0] ERR_PKT_TRUNC  = 2'd2;
  localparam logic [1:0] ERR_LEN_SHORT  = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [2:0]           version_number;
    logic [2:0]           protocol_id;
    logic [1:0]           length_of_length;
    logic [NIBBLE_W-1:0]  user_defined;
    logic [NIBBLE_W-1:0]  protocol_id_ext;
    logic [DEFINED_W-1:0] defined_field;
    logic [LENGTH_W-1:0]  total_length;
    logic [7:0]           payload_byte;
    logic                 last;
    logic [1:0]           error_code;
  } res_t;

  // Results pushed by the parser for one accepted byte
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic res_t make_error(input logic [1:0] code);
    res_t r;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.last       = 1'b1;
    r.error_code = code;
    return r;
  endfunction

  function automatic res_t make_payload(input logic [7:0] b, input logic fin);
    res_t r;
    r              = '0;
    r.kind         = KIND_PAYLOAD;
    r.payload_byte = b;
    r.last         = fin;
    return r;
  endfunction

endpackage

/* hw/rtl/epd_parser.sv */
// ----------------------------------------------------------------------------
// epd_parser
// Header/payload state machine: one byte per cycle while take is high, up to two results out.
// ----------------------------------------------------------------------------
module epd_parser
  import epd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       buffer_last,
  output push_t      push
);

  phase_t                phase_r, phase_nxt;
  logic [2:0]            hcnt_r, hcnt_nxt;
  logic [HDR_W-9:0]      hdr_r, hdr_nxt;
  logic [7:0]            first_r, first_nxt;
  logic [LENGTH_W-1:0]   rem_r, rem_nxt;

  logic                  in_hdr;
  logic [3:0]            cnt;
  logic [HDR_W-1:0]      hdr_sh;
  logic [7:0]            first;
  logic [1:0]            lol;
  logic [3:0]            need;
  logic [LENGTH_W-1:0]   need_w;
  logic                  hdr_done;
  logic [LENGTH_W-1:0]   len;
  logic [7:0]            second;
  logic [DEFINED_W-1:0]  def;
  logic                  len_short;
  logic [LENGTH_W-1:0]   rem;
  logic                  rem_zero;
  logic [LENGTH_W-1:0]   pay_rem;
  logic                  pay_last;
  res_t                  hdr_res;

  assign in_hdr   = (phase_r == PH_HEADER);
  assign cnt      = (in_hdr ? {1'b0, hcnt_r} : 4'd0) + 4'd1;
  assign hdr_sh   = {(in_hdr ? hdr_r : {(HDR_W-8){1'b0}}), data_byte};
  assign first    = (cnt == 4'd1) ? data_byte : first_r;
  assign lol      = first[1:0];
  assign need     = 4'd1 << lol;
  assign need_w   = {{(LENGTH_W-4){1'b0}}, need};
  assign hdr_done = (cnt >= need);

  always_comb begin
    len    = '0;
    second = '0;
    def    = '0;
    case (lol)
      2'd0: len = {{(LENGTH_W-1){1'b0}}, 1'b1};
      2'd1: len = {{(LENGTH_W-8){1'b0}}, hdr_sh[7:0]};
      2'd2: begin
        second = hdr_sh[23:16];
        len    = {{(LENGTH_W-16){1'b0}}, hdr_sh[15:0]};
      end
      2'd3: begin
        second = hdr_sh[55:48];
        def    = hdr_sh[47:32];
        len    = hdr_sh[31:0];
      end
      default: len = '0;
    endcase
  end

  assign len_short = (len < need_w);
  assign rem       = len - need_w;
  assign rem_zero  = (rem == '0);
  assign pay_rem   = rem_r - {{(LENGTH_W-1){1'b0}}, 1'b1};
  assign pay_last  = (pay_rem == '0);

  always_comb begin
    hdr_res                  = '0;
    hdr_res.kind             = KIND_HEADER;
    hdr_res.version_number   = first[7:5];
    hdr_res.protocol_id      = first[4:2];
    hdr_res.length_of_length = lol;
    hdr_res.user_defined     = second[7:4];
    hdr_res.protocol_id_ext  = second[3:0];
    hdr_res.defined_field    = def;
    hdr_res.total_length     = len;
    hdr_res.last             = rem_zero;
    hdr_res.error_code       = ERR_NONE;
  end

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    hdr_nxt   = hdr_r;
    first_nxt = first_r;
    rem_nxt   = rem_r;
    if (take) begin
      case (phase_r)
        PH_PAYLOAD: begin
          rem_nxt = pay_rem;
          if (pay_last) begin
            phase_nxt = PH_IDLE;
          end else if (buffer_last) begin
            phase_nxt = PH_IDLE;
            rem_nxt   = '0;
          end
        end
        default: begin
          if (!hdr_done) begin
            phase_nxt = PH_HEADER;
            hcnt_nxt  = cnt[2:0];
            hdr_nxt   = hdr_sh[HDR_W-9:0];
            first_nxt = first;
            if (buffer_last) begin
              phase_nxt = PH_IDLE;
              hcnt_nxt  = '0;
              hdr_nxt   = '0;
            end
          end else begin
            hcnt_nxt = '0;
            hdr_nxt  = '0;
            if (len_short || rem_zero || buffer_last) begin
              phase_nxt = PH_IDLE;
              rem_nxt   = '0;
            end else begin
              phase_nxt = PH_PAYLOAD;
              rem_nxt   = rem;
            end
          end
        end
      endcase
    end
  end

  // Outputs
  always_comb begin
    push.cnt = 2'd0;
    push.r0  = '0;
    push.r1  = make_error(ERR_PKT_TRUNC);
    if (take) begin
      case (phase_r)
        PH_PAYLOAD: begin
          push.r0  = make_payload(data_byte, pay_last);
          push.cnt = (!pay_last && buffer_last) ? 2'd2 : 2'd1;
        end
        default: begin
          if (!hdr_done) begin
            push.r0  = make_error(ERR_HDR_TRUNC);
            push.cnt = buffer_last ? 2'd1 : 2'd0;
          end else if (len_short) begin
            push.r0  = make_error(ERR_LEN_SHORT);
            push.cnt = 2'd1;
          end else begin
            push.r0  = hdr_res;
            push.cnt = (!rem_zero && buffer_last) ? 2'd2 : 2'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hcnt_r  <= '0;
      hdr_r   <= '0;
      rem_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      hdr_r   <= hdr_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
  end

endmodule

/* hw/rtl/epd_out_queue.sv */
// ----------------------------------------------------------------------------
// epd_out_queue
// Small result queue: takes up to two results a cycle, hands out one while out_ready is high.
// ----------------------------------------------------------------------------
module epd_out_queue
  import epd_pkg::*;
#(
  parameter int DEPTH = DEF_OUT_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  space_ok,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  res_t            q_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0]   wp1, wp2;
  logic [CW-1:0]   count_r, count_nxt;
  logic            pop;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wp1 = inc(wr_ptr_r);
  assign wp2 = inc(wp1);
  assign pop = (count_r != '0) && out_ready;

  always_comb begin
    case (push.cnt)
      2'd1:    wr_ptr_nxt = wp1;
      2'd2:    wr_ptr_nxt = wp2;
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = pop ? inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(push.cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (push.cnt != 2'd0 && wr_ptr_r == PW'(i)) begin
        q_r[i] <= push.r0;
      end else if (push.cnt == 2'd2 && wp1 == PW'(i)) begin
        q_r[i] <= push.r1;
      end
    end
  end

  // Keep room for a full two-result transaction; no path from out_ready
  assign space_ok  = (count_r <= CW'(DEPTH - 2));
  assign out_valid = (count_r != '0);
  assign out_res   = q_r[rd_ptr_r];

endmodule

/* hw/rtl/encapsulation_packet_deframer.sv */
// ----------------------------------------------------------------------------
// encapsulation_packet_deframer
// Encapsulation packet header parser with payload pass-through.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while in_ready is high, MSB first. Each accepted
// byte is parsed in the cycle it arrives and its results (none, one, or two
// when a buffer ends inside a packet) enter a small output queue of OUT_DEPTH
// entries; a result is registered there, shows on out_* behind earlier ones
// and leaves at one per cycle while out_ready is high. in_ready depends only
// on the queue fill: it is high while at least two entries are free, so with
// out_ready held high a new byte is taken every cycle; the output port limits
// throughput when a buffer end adds an error result.
module encapsulation_packet_deframer
  import epd_pkg::*;
#(
  parameter int OUT_DEPTH = DEF_OUT_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_buffer_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_kind,
  output logic [2:0]           out_version_number,
  output logic [2:0]           out_protocol_id,
  output logic [1:0]           out_length_of_length,
  output logic [NIBBLE_W-1:0]  out_user_defined,
  output logic [NIBBLE_W-1:0]  out_protocol_id_ext,
  output logic [DEFINED_W-1:0] out_defined_field,
  output logic [LENGTH_W-1:0]  out_total_length,
  output logic [7:0]           out_payload_byte,
  output logic                 out_last,
  output logic [1:0]           out_error_code
);

  push_t push;
  res_t  res;
  logic  take;

  assign take = in_valid && in_ready;

  epd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .data_byte   (in_data_byte),
    .buffer_last (in_buffer_last),
    .push        (push)
  );

  epd_out_queue #(
    .DEPTH (OUT_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_kind             = res.kind;
  assign out_version_number   = res.version_number;
  assign out_protocol_id      = res.protocol_id;
  assign out_length_of_length = res.length_of_length;
  assign out_user_defined     = res.user_defined;
  assign out_protocol_id_ext  = res.protocol_id_ext;
  assign out_defined_field    = res.defined_field;
  assign out_total_length     = res.total_length;
  assign out_payload_byte     = res.payload_byte;
  assign out_last             = res.last;
  assign out_error_code       = res.error_code;

endmodule

/* bench/encapsulation_packet_deframer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encapsulation_packet_deframer_tb
// Self-checking bench for the encapsulation packet deframer.
// ----------------------------------------------------------------------------
// Feeds byte streams of encapsulation packets (all header sizes, packets with
// and without payload, buffers cut inside header and payload, lengths below
// the header size, and raw noise) with random stalls on both channels. A
// behavioral parser predicts every header, payload and error result, and
// each result is checked field by field in order.
// ----------------------------------------------------------------------------
module encapsulation_packet_deframer_tb;
  import epd_pkg::*;

  localparam int          CYCLE_LIMIT = 500000;
  localparam int          TAIL_BYTES  = 150;
  localparam int          RANDOM_BYTES = 1900;

  typedef struct packed {
    logic [7:0] data;
    logic       buf_last;
  } stream_byte_t;

  typedef enum int {
    SC_GOOD,
    SC_HDR_CUT,
    SC_PKT_CUT,
    SC_SHORT,
    SC_NOISE
  } scenario_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_data_byte = '0;
  logic                 in_buffer_last = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           out_kind;
  logic [2:0]           out_version_number;
  logic [2:0]           out_protocol_id;
  logic [1:0]           out_length_of_length;
  logic [NIBBLE_W-1:0]  out_user_defined;
  logic [NIBBLE_W-1:0]  out_protocol_id_ext;
  logic [DEFINED_W-1:0] out_defined_field;
  logic [LENGTH_W-1:0]  out_total_length;
  logic [7:0]           out_payload_byte;
  logic                 out_last;
  logic [1:0]           out_error_code;

  encapsulation_packet_deframer u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data_byte         (in_data_byte),
    .in_buffer_last       (in_buffer_last),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_kind             (out_kind),
    .out_version_number   (out_version_number),
    .out_protocol_id      (out_protocol_id),
    .out_length_of_length (out_length_of_length),
    .out_user_defined     (out_user_defined),
    .out_protocol_id_ext  (out_protocol_id_ext),
    .out_defined_field    (out_defined_field),
    .out_total_length     (out_total_length),
    .out_payload_byte     (out_payload_byte),
    .out_last             (out_last),
    .out_error_code       (out_error_code)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  stream_byte_t byte_stream[$];
  res_t         expected_results[$];

  // parser state mirrored from the block
  phase_t       ps_phase = PH_IDLE;
  int           ps_count = 0;
  logic [63:0]  ps_header = '0;
  logic [31:0]  ps_remaining = '0;

  int           mismatches = 0;
  int           bytes_taken = 0;
  int           headers_seen = 0;
  int           payload_seen = 0;
  int           errors_seen[4] = '{0, 0, 0, 0};
  int           cycles = 0;
  int           in_gap = 0;
  int           out_gap = 0;
  bit           tail_part = 1'b0;
  bit           calm = 1'b0;

  function automatic res_t error_result(input logic [1:0] code);
    res_t r;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.last       = 1'b1;
    r.error_code = code;
    return r;
  endfunction

  function automatic res_t payload_result(input logic [7:0] b, input logic fin);
    res_t r;
    r              = '0;
    r.kind         = KIND_PAYLOAD;
    r.payload_byte = b;
    r.last         = fin;
    return r;
  endfunction

  task automatic clear_parser();
    ps_phase     = PH_IDLE;
    ps_count     = 0;
    ps_header    = '0;
    ps_remaining = '0;
  endtask

  // Work out the results that one accepted byte causes.
  task automatic deframe_byte(input logic [7:0] b, input logic blast);
    res_t        r;
    int          cnt;
    int          need;
    logic [7:0]  first;
    logic [7:0]  second;
    logic [1:0]  lol;
    logic [15:0] def;
    logic [31:0] len;
    logic [31:0] rem;
    if (ps_phase == PH_PAYLOAD) begin
      ps_remaining = ps_remaining - 1;
      if (ps_remaining == 0) begin
        expected_results.push_back(payload_result(b, 1'b1));
        ps_phase = PH_IDLE;
      end else begin
        expected_results.push_back(payload_result(b, 1'b0));
        if (blast) begin
          expected_results.push_back(error_result(ERR_PKT_TRUNC));
          clear_parser();
        end
      end
      return;
    end
    if (ps_phase != PH_HEADER) begin
      ps_count  = 0;
      ps_header = '0;
      ps_phase  = PH_HEADER;
    end
    ps_header = {ps_header[55:0], b};
    cnt       = ps_count + 1;
    first     = ps_header[(cnt-1)*8 +: 8];
    lol       = first[1:0];
    need      = 1 << lol;
    if (cnt < need) begin
      ps_count = cnt;
      if (blast) begin
        expected_results.push_back(error_result(ERR_HDR_TRUNC));
        clear_parser();
      end
      return;
    end
    second = '0;
    def    = '0;
    case (lol)
      2'd0: len = 32'd1;
      2'd1: len = {24'd0, ps_header[7:0]};
      2'd2: begin
        second = ps_header[23:16];
        len    = {16'd0, ps_header[15:0]};
      end
      default: begin
        second = ps_header[55:48];
        def    = ps_header[47:32];
        len    = ps_header[31:0];
      end
    endcase
    if (len < need) begin
      expected_results.push_back(error_result(ERR_LEN_SHORT));
      clear_parser();
      return;
    end
    rem                = len - need;
    r                  = '0;
    r.kind             = KIND_HEADER;
    r.version_number   = first[7:5];
    r.protocol_id      = first[4:2];
    r.length_of_length = lol;
    r.user_defined     = second[7:4];
    r.protocol_id_ext  = second[3:0];
    r.defined_field    = def;
    r.total_length     = len;
    r.last             = (rem == 0);
    expected_results.push_back(r);
    ps_count  = 0;
    ps_header = '0;
    if (rem == 0) begin
      ps_phase     = PH_IDLE;
      ps_remaining = '0;
    end else if (blast) begin
      expected_results.push_back(error_result(ERR_PKT_TRUNC));
      clear_parser();
    end else begin
      ps_phase     = PH_PAYLOAD;
      ps_remaining = rem;
    end
  endtask

  task automatic add_byte(input logic [7:0] data, input logic buf_last);
    stream_byte_t sb;
    sb.data     = data;
    sb.buf_last = buf_last;
    byte_stream.push_back(sb);
  endtask

  // Queue the first nsend bytes of a packet; payload content is random.
  task automatic add_packet(input logic [2:0] ver, input logic [2:0] pid,
                            input logic [1:0] lol, input logic [7:0] second,
                            input logic [15:0] def, input logic [31:0] len,
                            input int nsend, input logic end_flag);
    logic [7:0] hdr[8];
    int         need;
    need   = 1 << lol;
    hdr    = '{default: 8'd0};
    hdr[0] = {ver, pid, lol};
    case (lol)
      2'd1: hdr[1] = len[7:0];
      2'd2: begin
        hdr[1] = second;
        hdr[2] = len[15:8];
        hdr[3] = len[7:0];
      end
      2'd3: begin
        hdr[1] = second;
        hdr[2] = def[15:8];
        hdr[3] = def[7:0];
        hdr[4] = len[31:24];
        hdr[5] = len[23:16];
        hdr[6] = len[15:8];
        hdr[7] = len[7:0];
      end
      default: ;
    endcase
    for (int i = 0; i < nsend; i++)
      add_byte(i < need ? hdr[i] : 8'($urandom), end_flag && (i == nsend - 1));
  endtask

  task automatic add_random_scenario();
    scenario_t   sc;
    int          pick;
    logic [1:0]  lol;
    int          need;
    int          n;
    int          lo;
    logic [31:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 65)      sc = SC_GOOD;
    else if (pick < 75) sc = SC_HDR_CUT;
    else if (pick < 85) sc = SC_PKT_CUT;
    else if (pick < 93) sc = SC_SHORT;
    else                sc = SC_NOISE;
    lol  = (sc == SC_GOOD) ? 2'($urandom_range(0, 3)) : 2'($urandom_range(1, 3));
    need = 1 << lol;
    case (sc)
      SC_GOOD: begin
        n   = (lol == 2'd0) ? 0 :
              ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
        len = need + n;
        add_packet(3'($urandom), 3'($urandom), lol, 8'($urandom), 16'($urandom), len,
                   need + n, $urandom_range(0, 3) == 0);
      end
      SC_HDR_CUT:
        add_packet(3'($urandom), 3'($urandom), lol, 8'($urandom), 16'($urandom), $urandom,
                   $urandom_range(1, need - 1), 1'b1);
      SC_PKT_CUT: begin
        n  = $urandom_range(0, 4);
        lo = need + n + 1;
        case (lol)
          2'd1:    len = $urandom_range(lo, 255);
          2'd2:    len = $urandom_range(lo, 65535);
          default: begin
            len = $urandom;
            if (len < lo) len = lo;
          end
        endcase
        add_packet(3'($urandom), 3'($urandom), lol, 8'($urandom), 16'($urandom), len,
                   need + n, 1'b1);
      end
      SC_SHORT:
        add_packet(3'($urandom), 3'($urandom), lol, 8'($urandom), 16'($urandom),
                   $urandom_range(0, need - 1), need, 1'($urandom_range(0, 1)));
      default: begin
        // raw bytes; the buffer end brings the parser back to a header start
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          add_byte(8'($urandom), i == n - 1);
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 30)
      $display("mismatch %0d at cycle %0d: %s got 0x%0h expected 0x%0h",
               mismatches, cycles, what, got, want);
  endtask

  task automatic check_result();
    res_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with nothing expected, kind", 32'(out_kind), 0);
      return;
    end
    want = expected_results.pop_front();
    if (out_kind !== want.kind)
      report_mismatch("kind", 32'(out_kind), 32'(want.kind));
    if (out_version_number !== want.version_number)
      report_mismatch("version_number", 32'(out_version_number),
                      32'(want.version_number));
    if (out_protocol_id !== want.protocol_id)
      report_mismatch("protocol_id", 32'(out_protocol_id), 32'(want.protocol_id));
    if (out_length_of_length !== want.length_of_length)
      report_mismatch("length_of_length", 32'(out_length_of_length),
                      32'(want.length_of_length));
    if (out_user_defined !== want.user_defined)
      report_mismatch("user_defined", 32'(out_user_defined), 32'(want.user_defined));
    if (out_protocol_id_ext !== want.protocol_id_ext)
      report_mismatch("protocol_id_ext", 32'(out_protocol_id_ext),
                      32'(want.protocol_id_ext));
    if (out_defined_field !== want.defined_field)
      report_mismatch("defined_field", 32'(out_defined_field), 32'(want.defined_field));
    if (out_total_length !== want.total_length)
      report_mismatch("total_length", out_total_length, want.total_length);
    if (out_payload_byte !== want.payload_byte)
      report_mismatch("payload_byte", 32'(out_payload_byte), 32'(want.payload_byte));
    if (out_last !== want.last)
      report_mismatch("last", 32'(out_last), 32'(want.last));
    if (out_error_code !== want.error_code)
      report_mismatch("error_code", 32'(out_error_code), 32'(want.error_code));
    case (want.kind)
      KIND_HEADER:  headers_seen++;
      KIND_PAYLOAD: payload_seen++;
      default:      errors_seen[want.error_code]++;
    endcase
  endtask

  // Input driver: hold the transaction until accepted, then advance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid       <= 1'b0;
      in_data_byte   <= '0;
      in_buffer_last <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        deframe_byte(in_data_byte, in_buffer_last);
        bytes_taken++;
      end
      if (!in_valid || in_ready) begin
        tail_part = byte_stream.size() < TAIL_BYTES;
        if ($urandom_range(0, 199) == 0) calm = !calm;
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (byte_stream.size() > 0) begin
          in_valid       <= 1'b1;
          in_data_byte   <= byte_stream[0].data;
          in_buffer_last <= byte_stream[0].buf_last;
          void'(byte_stream.pop_front());
          if (!tail_part && !calm && $urandom_range(0, 7) == 0)
            in_gap = $urandom_range(1, 8);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        check_result();
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!tail_part && !calm && $urandom_range(0, 7) == 0)
          out_gap = $urandom_range(1, 8);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_results.size());
      $display("FAIL encapsulation_packet_deframer");
      $finish;
    end
  end

  initial begin
    // directed: header sizes, field extremes, every error, buffer ends
    add_packet(3'd0, 3'd0, 2'd0, 8'h00, 16'h0000, 32'd1, 1, 1'b0);
    add_packet(3'd7, 3'd7, 2'd0, 8'h00, 16'h0000, 32'd1, 1, 1'b1);
    add_packet(3'd0, 3'd0, 2'd1, 8'h00, 16'h0000, 32'd2, 2, 1'b0);
    add_packet(3'd7, 3'd7, 2'd1, 8'h00, 16'h0000, 32'd1, 2, 1'b0);
    add_packet(3'd1, 3'd1, 2'd1, 8'h00, 16'h0000, 32'd4, 4, 1'b1);
    add_packet(3'd2, 3'd5, 2'd2, 8'hFF, 16'h0000, 32'd6, 2, 1'b1);
    add_packet(3'd7, 3'd7, 2'd3, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 9, 1'b1);
    add_packet(3'd3, 3'd2, 2'd2, 8'hA5, 16'h0000, 32'd6, 4, 1'b1);
    while (byte_stream.size() < RANDOM_BYTES + 25)
      add_random_scenario();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_stream.size() != 0 || in_valid)
      @(posedge clk);
    while (expected_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d bytes: %0d headers, %0d payload bytes", bytes_taken,
             headers_seen, payload_seen);
    $display("errors: header cut %0d, packet cut %0d, length short %0d",
             errors_seen[ERR_HDR_TRUNC], errors_seen[ERR_PKT_TRUNC],
             errors_seen[ERR_LEN_SHORT]);
    if (mismatches == 0) begin
      $display("PASS encapsulation_packet_deframer");
    end else begin
      $display("FAIL encapsulation_packet_deframer");
    end
    $finish;
  end

endmodule
